@@ hdl/two_key_top_k_ranker_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the two-key top-K ranker
// Shared forms for the concurrent checks, clocked on clk and held off by reset.
// ---------------------------------------------------------------------------
`ifndef TWO_KEY_TOP_K_RANKER_MACROS_SVH
`define TWO_KEY_TOP_K_RANKER_MACROS_SVH

// Same-cycle implication.
`define TKR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TKR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tkr_pkg.sv @@
// ---------------------------------------------------------------------------
// Two-key top-K ranker package
// Record types, link types between cells, constants and the ranking compare.
// ---------------------------------------------------------------------------
package tkr_pkg;

	localparam int TAG_W       = 16;
	localparam int SCORE_W     = 24;
	localparam int STAGE_W     = 8;
	localparam int RANK_W      = 4;
	localparam int READOUT_MAX = 10;

	localparam logic MODE_INSERT  = 1'b0;
	localparam logic MODE_READOUT = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SCORE_W-1:0] score;
		logic [STAGE_W-1:0] stage;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} cell_link_t;

	typedef struct packed {
		logic ins;
		logic rot;
	} cell_ctrl_t;

	// True when record a ranks strictly above record b.
	function automatic logic ranks_above(rec_t a, rec_t b);
		if (a.stage != b.stage) begin
			return a.stage > b.stage;
		end
		return a.score > b.score;
	endfunction

endpackage

@@ hdl/tkr_cell.sv @@
// ---------------------------------------------------------------------------
// Ranker cell
// Holds one table slot; on insert it keeps, takes the new record or takes its
// upper neighbour's record, and on rotation takes its lower neighbour's.
// ---------------------------------------------------------------------------
module tkr_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tkr_pkg::cell_ctrl_t ctrl,
	input  tkr_pkg::rec_t       new_rec,
	input  logic                prev_take,
	input  tkr_pkg::cell_link_t prev_link,
	input  tkr_pkg::cell_link_t next_link,
	output logic                take,
	output tkr_pkg::cell_link_t link
);
	import tkr_pkg::*;

	logic valid_q;
	rec_t rec_q;

	assign take = !valid_q || ranks_above(new_rec, rec_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.rot) begin
			valid_q <= next_link.valid;
		end else if (ctrl.ins && take) begin
			valid_q <= prev_take ? prev_link.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rot) begin
			rec_q <= next_link.rec;
		end else if (ctrl.ins && take) begin
			rec_q <= prev_take ? prev_link.rec : new_rec;
		end
	end

	assign link.valid = valid_q;
	assign link.rec   = rec_q;

endmodule

@@ hdl/tkr_readout.sv @@
// ---------------------------------------------------------------------------
// Ranker readout sequencer
// Rotates the cell chain once round, emitting the head cell's entry into the
// output register for each ranked position that is reported.
// ---------------------------------------------------------------------------
module tkr_readout #(
	parameter int TOP_K = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(TOP_K+1)-1:0]    held,
	input  tkr_pkg::cell_link_t           head,
	input  logic                          rsp_stall,
	output logic                          busy,
	output logic                          rot,
	output logic                          rsp_valid,
	output logic [tkr_pkg::RANK_W-1:0]    rank_position,
	output logic                          entry_valid,
	output logic [tkr_pkg::TAG_W-1:0]     out_tag,
	output logic [tkr_pkg::SCORE_W-1:0]   out_score,
	output logic [tkr_pkg::STAGE_W-1:0]   out_stage,
	output logic                          last
);
	import tkr_pkg::*;

	localparam int CNT_W  = $clog2(TOP_K + 1);
	localparam int STEP_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  emit_n;
	logic              out_free;
	logic              emitting;
	logic              is_empty;
	logic              end_step;
	logic              load_rsp;

	assign emit_n   = (32'(held) > READOUT_MAX) ? CNT_W'(READOUT_MAX) : held;
	assign out_free = !rsp_valid || !rsp_stall;
	assign emitting = 32'(step_q) < 32'(emit_n);
	assign is_empty = (held == '0);
	assign end_step = 32'(step_q) == TOP_K - 1;
	assign busy     = (state_q != IDLE);
	assign load_rsp = (state_q == RUN) && (is_empty ? out_free : (rot && emitting));

	always_comb begin
		rot = 1'b0;
		if (state_q == RUN && !is_empty) begin
			rot = !emitting || out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			step_q        <= '0;
			rsp_valid     <= 1'b0;
			rank_position <= '0;
			entry_valid   <= 1'b0;
			out_tag       <= '0;
			out_score     <= '0;
			out_stage     <= '0;
			last          <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					step_q <= '0;
					if (start) begin
						state_q <= RUN;
					end
				end
				RUN: begin
					if (is_empty) begin
						if (out_free) begin
							rank_position <= '0;
							entry_valid   <= 1'b0;
							out_tag       <= '0;
							out_score     <= '0;
							out_stage     <= '0;
							last          <= 1'b1;
							state_q       <= IDLE;
						end
					end else if (rot) begin
						if (emitting) begin
							rank_position <= RANK_W'(step_q);
							entry_valid   <= 1'b1;
							out_tag       <= head.rec.tag;
							out_score     <= head.rec.score;
							out_stage     <= head.rec.stage;
							last          <= (32'(step_q) + 1 == 32'(emit_n));
						end
						if (end_step) begin
							step_q  <= '0;
							state_q <= IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

@@ hdl/two_key_top_k_ranker.sv @@
// ---------------------------------------------------------------------------
// Two-key top-K ranker
// Ranked table of the best TOP_K records, ordered by stage and then score.
// ---------------------------------------------------------------------------
// An insert transaction is taken at once and, while no readout runs, inserts
// can follow one another in every cycle: every cell of the chain compares the
// new record with its own slot at once and shifts or loads in that cycle. A
// readout transaction occupies the block until the chain has rotated once
// round through the head cell, one slot per cycle while the result side does
// not stall, to present entries in rank order and restore the table; the
// first result is registered after the sequencer has entered its run state,
// and an empty table gives its single result from that state and ends. No
// request is taken while a readout runs. Equal records keep arrival order and
// the table is empty after reset.
module two_key_top_k_ranker #(
	parameter int TOP_K = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          mode,
	input  logic [tkr_pkg::TAG_W-1:0]     player_tag,
	input  logic [tkr_pkg::SCORE_W-1:0]   score,
	input  logic [tkr_pkg::STAGE_W-1:0]   stage,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [tkr_pkg::RANK_W-1:0]    rank_position,
	output logic                          entry_valid,
	output logic [tkr_pkg::TAG_W-1:0]     out_tag,
	output logic [tkr_pkg::SCORE_W-1:0]   out_score,
	output logic [tkr_pkg::STAGE_W-1:0]   out_stage,
	output logic                          last
);
	import tkr_pkg::*;
	`include "two_key_top_k_ranker_macros.svh"

	localparam int CNT_W = $clog2(TOP_K + 1);

	logic             req_fire;
	logic             busy;
	logic             rot;
	logic [CNT_W-1:0] held_q;
	rec_t             new_rec;
	cell_ctrl_t       ctrl;
	cell_link_t       links [TOP_K];
	logic [TOP_K-1:0] takes;
	logic [TOP_K-1:0] cell_valid;
	logic             held_ok;
	logic             ins_room;

	assign req_stall     = busy;
	assign req_fire      = req_valid && !req_stall;
	assign new_rec.tag   = player_tag;
	assign new_rec.score = score;
	assign new_rec.stage = stage;
	assign ctrl.ins      = req_fire && (mode == MODE_INSERT);
	assign ctrl.rot      = rot;

	genvar gi;
	generate
		for (gi = 0; gi < TOP_K; gi++) begin : g_cell
			localparam int NXT = (gi + 1) % TOP_K;
			logic       prev_take;
			cell_link_t prev_link;

			if (gi == 0) begin : g_head
				assign prev_take = 1'b0;
				assign prev_link = '0;
			end else begin : g_body
				assign prev_take = takes[gi-1];
				assign prev_link = links[gi-1];
			end

			tkr_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.new_rec   (new_rec),
				.prev_take (prev_take),
				.prev_link (prev_link),
				.next_link (links[NXT]),
				.take      (takes[gi]),
				.link      (links[gi])
			);

			assign cell_valid[gi] = links[gi].valid;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ctrl.ins && held_q != CNT_W'(TOP_K)) begin
			held_q <= held_q + 1'b1;
		end
	end

	tkr_readout #(
		.TOP_K (TOP_K)
	) u_readout (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (req_fire && (mode == MODE_READOUT)),
		.held          (held_q),
		.head          (links[0]),
		.rsp_stall     (rsp_stall),
		.busy          (busy),
		.rot           (rot),
		.rsp_valid     (rsp_valid),
		.rank_position (rank_position),
		.entry_valid   (entry_valid),
		.out_tag       (out_tag),
		.out_score     (out_score),
		.out_stage     (out_stage),
		.last          (last)
	);

	assign held_ok  = ($countones(cell_valid) == 32'(held_q));
	assign ins_room = ctrl.ins && (32'(held_q) < TOP_K);

	`TKR_ASSERT_NOW(a_held_matches_cells, 1'b1, held_ok, "held count disagrees with cells")
	`TKR_ASSERT_NEXT(a_insert_grows, ins_room, held_q == $past(held_q) + 1'b1, "no growth")
	`TKR_ASSERT_NOW(a_no_insert_in_rotation, rot, !ctrl.ins, "insert taken in rotation")

endmodule
